// ===== src/mqm_pkg.sv =====
// mqm_pkg: shared types and codes of the multi queue manager
// field widths, command and status codes, control state type
// used by multi_queue_manager_core and its port checker
package mqm_pkg;

    // payload field widths
    localparam int ACTION_W = 1;
    localparam int QIDX_W   = 4;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    // queues_in_use after reset
    localparam logic [CFG_W-1:0] QUEUES_IN_USE_RST = 5'd16;

    // command codes
    localparam logic [ACTION_W-1:0] ACT_ADD    = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // command sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UNLINK,
        S_HOLD
    } t_state;

endpackage

// ===== src/multi_queue_manager_core.sv =====
// multi_queue_manager_core: byte queues in one shared entry pool with a free list
// entry symbols, entry links and queue records sit in synchronous memories
// depends on mqm_pkg
//
// Usage:
// - command channel i_valid/o_stall carries action, queue index and symbol;
//   a transfer happens at a clock edge with i_valid high and o_stall low
// - result channel o_valid/i_stall carries removed symbol, its valid flag and
//   a status code; exactly one result per command, in command order
// - i_cfg_we writes i_cfg_wdata into queues_in_use; user writes it only while
//   no command is open; the block leaves that check to the user
// Command steps:
// - add, pool full, queue empty and bad index: record read at the transfer,
//   result registered from the lookup state, then idle for the next command
// - remove: head record read, then head entry symbol and link read, then result
//   registered from the unlink state; the link read depends on the record read
// Reset: synchronous, active low; all queues empty, all entries free, no memory
//   sweep, commands taken as soon as reset is released
// Stall: a finished result waits in the output register; the next command is
//   taken and worked on, and its result waits in a hold stage until the
//   output register frees up
module multi_queue_manager_core #(
    parameter int NUM_QUEUES   = 16,
    parameter int POOL_ENTRIES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mqm_pkg::ACTION_W-1:0]  i_action,
    input  logic [mqm_pkg::QIDX_W-1:0]    i_queue_index,
    input  logic [mqm_pkg::SYM_W-1:0]     i_symbol,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mqm_pkg::SYM_W-1:0]     o_removed_symbol,
    output logic                          o_removed_valid,
    output logic [mqm_pkg::STATUS_W-1:0]  o_status,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [mqm_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import mqm_pkg::*;

    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int CW = $clog2(POOL_ENTRIES + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
        logic [CW-1:0] len;
    } t_qrec;

    // successor of an entry in the reset link chain
    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        f_next = (p == PW'(POOL_ENTRIES - 1)) ? '0 : p + PW'(1);
    endfunction

    // memories
    logic [SYM_W-1:0] m_sym  [POOL_ENTRIES];
    logic [PW-1:0]    m_link [POOL_ENTRIES];
    t_qrec            m_queue[NUM_QUEUES];

    // control registers
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_cfg;
    logic [PW-1:0]       r_free_head, n_free_head;
    logic [CW-1:0]       r_free_cnt, n_free_cnt;
    logic [CW-1:0]       r_fresh, n_fresh;
    logic [NUM_QUEUES-1:0] r_qvalid;
    logic                r_out_valid;

    // command and read data registers
    logic [ACTION_W-1:0] r_action;
    logic [QIDX_W-1:0]   r_q;
    logic [SYM_W-1:0]    r_sym;
    t_qrec               r_q_rd;
    logic                r_qv_rd;
    logic [PW-1:0]       r_link_rd;
    logic [SYM_W-1:0]    r_sym_rd;
    logic [SYM_W-1:0]    r_res_sym;
    logic                r_res_valid;
    logic [STATUS_W-1:0] r_res_status;

    // decoded command flags
    logic          bad, is_add, pool_empty, q_empty;
    logic [PW-1:0] q_head, q_tail;
    logic [CW-1:0] q_len;
    logic [PW-1:0] alloc_link;
    logic          out_free;

    // memory ports and result
    logic          q_re, q_we;
    t_qrec         q_wd;
    logic          link_re, link_we;
    logic [PW-1:0] link_ra, link_wa, link_wd;
    logic          sym_re, sym_we;
    logic [PW-1:0] sym_ra, sym_wa;
    logic          free_upd, finish, load_now, load_hold;
    logic [SYM_W-1:0]    res_sym;
    logic                res_valid;
    logic [STATUS_W-1:0] res_status;

    // flags from the latched command and the queue record read
    always_comb begin
        q_len      = r_qv_rd ? r_q_rd.len  : '0;
        q_head     = r_qv_rd ? r_q_rd.head : '0;
        q_tail     = r_qv_rd ? r_q_rd.tail : '0;
        bad        = ({28'd0, r_q} >= 32'(NUM_QUEUES)) || ({1'b0, r_q} >= r_cfg);
        is_add     = (r_action == ACT_ADD);
        pool_empty = (r_free_cnt == '0);
        q_empty    = (q_len == '0);
        // entries never handed out have no stored link; their reset link comes from f_next
        alloc_link = (CW'(r_free_head) >= r_fresh) ? f_next(r_free_head) : r_link_rd;
        out_free   = !r_out_valid || !i_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                if (!bad && !is_add && !q_empty) n_state = S_UNLINK;
                else if (out_free)               n_state = S_IDLE;
                else                             n_state = S_HOLD;
            end
            S_UNLINK: begin
                n_state = out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory accesses, pool pointer updates and result per state
    always_comb begin
        q_re        = 1'b0;
        q_we        = 1'b0;
        q_wd        = r_q_rd;
        link_re     = 1'b0;
        link_we     = 1'b0;
        link_ra     = r_free_head;
        link_wa     = q_tail;
        link_wd     = r_free_head;
        sym_re      = 1'b0;
        sym_we      = 1'b0;
        sym_ra      = q_head;
        sym_wa      = r_free_head;
        free_upd    = 1'b0;
        n_free_head = r_free_head;
        n_free_cnt  = r_free_cnt;
        n_fresh     = r_fresh;
        finish      = 1'b0;
        res_sym     = '0;
        res_valid   = 1'b0;
        res_status  = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                // record of the addressed queue and link of the free head
                q_re    = i_valid;
                link_re = i_valid;
            end
            S_LOOKUP: begin
                if (bad) begin
                    res_status = ST_BAD_INDEX;
                    finish     = 1'b1;
                end else if (is_add) begin
                    finish = 1'b1;
                    if (pool_empty) begin
                        res_status = ST_FULL;
                    end else begin
                        // take the free head and append it to the queue
                        sym_we      = 1'b1;
                        link_we     = !q_empty;
                        q_we        = 1'b1;
                        q_wd.head   = q_empty ? r_free_head : q_head;
                        q_wd.tail   = r_free_head;
                        q_wd.len    = q_len + CW'(1);
                        free_upd    = 1'b1;
                        n_free_head = alloc_link;
                        n_free_cnt  = r_free_cnt - CW'(1);
                        if (CW'(r_free_head) >= r_fresh) n_fresh = r_fresh + CW'(1);
                    end
                end else if (q_empty) begin
                    res_status = ST_EMPTY;
                    finish     = 1'b1;
                end else begin
                    // fetch symbol and link of the head entry
                    sym_re  = 1'b1;
                    link_re = 1'b1;
                    link_ra = q_head;
                end
            end
            S_UNLINK: begin
                // unlink the head entry and push it onto the free list
                res_sym     = r_sym_rd;
                res_valid   = 1'b1;
                finish      = 1'b1;
                q_we        = 1'b1;
                q_wd.head   = r_link_rd;
                q_wd.tail   = q_tail;
                q_wd.len    = q_len - CW'(1);
                link_we     = 1'b1;
                link_wa     = q_head;
                link_wd     = r_free_head;
                free_upd    = 1'b1;
                n_free_head = q_head;
                n_free_cnt  = r_free_cnt + CW'(1);
            end
            S_HOLD: begin
            end
            default: begin
            end
        endcase
        load_now  = finish && out_free;
        load_hold = (r_state == S_HOLD) && out_free;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= QUEUES_IN_USE_RST;
            r_free_head <= '0;
            r_free_cnt  <= CW'(POOL_ENTRIES);
            r_fresh     <= '0;
            r_qvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (free_upd) begin
                r_free_head <= n_free_head;
                r_free_cnt  <= n_free_cnt;
                r_fresh     <= n_fresh;
            end
            if (q_we) r_qvalid[QW'(r_q)] <= 1'b1;
            if (load_now || load_hold) r_out_valid <= 1'b1;
            else if (!i_stall)         r_out_valid <= 1'b0;
        end
    end

    // command capture and queue record memory
    always_ff @(posedge i_clk) begin
        if (q_re) begin
            r_action <= i_action;
            r_q      <= i_queue_index;
            r_sym    <= i_symbol;
            r_q_rd   <= m_queue[QW'(i_queue_index)];
            r_qv_rd  <= r_qvalid[QW'(i_queue_index)];
        end
        if (q_we) m_queue[QW'(r_q)] <= q_wd;
    end

    // entry link memory
    always_ff @(posedge i_clk) begin
        if (link_re) r_link_rd <= m_link[link_ra];
        if (link_we) m_link[link_wa] <= link_wd;
    end

    // entry symbol memory
    always_ff @(posedge i_clk) begin
        if (sym_re) r_sym_rd <= m_sym[sym_ra];
        if (sym_we) m_sym[sym_wa] <= r_sym;
    end

    // result hold stage and output register
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_res_sym    <= res_sym;
            r_res_valid  <= res_valid;
            r_res_status <= res_status;
        end
        if (load_now) begin
            o_removed_symbol <= res_sym;
            o_removed_valid  <= res_valid;
            o_status         <= res_status;
        end else if (load_hold) begin
            o_removed_symbol <= r_res_sym;
            o_removed_valid  <= r_res_valid;
            o_status         <= r_res_status;
        end
    end

endmodule

// ===== src/mqm_checker.sv =====
// mqm_checker: port level checks of multi_queue_manager_core
// watches the command handshake and the result channel only
// depends on mqm_pkg; bound into the core at the end of this file
module mqm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [mqm_pkg::SYM_W-1:0]     o_removed_symbol,
    input logic                          o_removed_valid,
    input logic [mqm_pkg::STATUS_W-1:0]  o_status
);
    import mqm_pkg::*;

    // a delivered symbol only comes with ok status
    a_valid_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_removed_valid |-> o_status == ST_OK)
        else $error("removed symbol flagged with error status");

    // no symbol without its valid flag
    a_symbol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_removed_valid |-> o_removed_symbol == 8'd0)
        else $error("nonzero symbol without valid flag");

    // one command at a time: the transfer closes the command port
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("command port open right after a transfer");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_removed_symbol)
            && $stable(o_removed_valid) && $stable(o_status))
        else $error("stalled result changed");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind multi_queue_manager_core mqm_checker u_mqm_checker (.*);
